[hdl/mat3_inverse_adjugate_defines.svh]
// Assertion macros shared by the checker of the 3x3 inverse block.
`ifndef MAT3_INVERSE_ADJUGATE_DEFINES_SVH
`define MAT3_INVERSE_ADJUGATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mi3_pkg.sv]
// Shared constants and types of the 3x3 inverse block.
`timescale 1ns / 1ps
package mi3_pkg;
    localparam int ELEM_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } mi3_qstat_t;
endpackage

[hdl/mi3_queue.sv]
// Small flop queue between the cofactor front and the divide back end.
`timescale 1ns / 1ps
module mi3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output mi3_pkg::mi3_qstat_t stat
);
    import mi3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (AW+1)'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

[hdl/mi3_front.sv]
// Front end: takes matrices and forms the nine signed cofactors.
`timescale 1ns / 1ps
module mi3_front #(
    parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [ELEM_BITS-1:0]                    s_m00,
    input  logic [ELEM_BITS-1:0]                    s_m01,
    input  logic [ELEM_BITS-1:0]                    s_m02,
    input  logic [ELEM_BITS-1:0]                    s_m10,
    input  logic [ELEM_BITS-1:0]                    s_m11,
    input  logic [ELEM_BITS-1:0]                    s_m12,
    input  logic [ELEM_BITS-1:0]                    s_m20,
    input  logic [ELEM_BITS-1:0]                    s_m21,
    input  logic [ELEM_BITS-1:0]                    s_m22,
    output logic                                    q_push,
    output logic [3*ELEM_BITS+9*(2*ELEM_BITS+1)-1:0] q_data,
    input  mi3_pkg::mi3_qstat_t                     q_stat
);
    import mi3_pkg::*;

    localparam int E  = ELEM_BITS;
    localparam int PW = 2 * E;
    localparam int CW = 2 * E + 1;

    // cofactor n = p(IA,IB) - p(IC,ID), negated for odd n
    localparam int IA [9] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
    localparam int IB [9] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
    localparam int IC [9] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
    localparam int ID [9] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};

    logic [E-1:0]         e_in [9];
    logic [E-1:0]         e_reg [9];
    logic signed [PW-1:0] pa_reg [9];
    logic signed [PW-1:0] pb_reg [9];
    logic [E-1:0]         row2_reg [3];
    logic [CW-1:0]        cof_reg [9];
    logic [E-1:0]         row3_reg [3];
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 adv;

    assign e_in[0] = s_m00;
    assign e_in[1] = s_m01;
    assign e_in[2] = s_m02;
    assign e_in[3] = s_m10;
    assign e_in[4] = s_m11;
    assign e_in[5] = s_m12;
    assign e_in[6] = s_m20;
    assign e_in[7] = s_m21;
    assign e_in[8] = s_m22;

    assign adv     = !(v3_reg && q_stat.full);
    assign s_ready = adv;
    assign q_push  = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    for (genvar n = 0; n < 9; n++) begin : g_cof
        logic [CW-1:0] ea, eb, diff;
        assign ea   = {pa_reg[n][PW-1], pa_reg[n]};
        assign eb   = {pb_reg[n][PW-1], pb_reg[n]};
        assign diff = (n % 2 == 1) ? (eb - ea) : (ea - eb);

        always_ff @(posedge aclk) begin
            if (adv) begin
                e_reg[n]   <= e_in[n];
                pa_reg[n]  <= $signed(e_reg[IA[n]]) * $signed(e_reg[IB[n]]);
                pb_reg[n]  <= $signed(e_reg[IC[n]]) * $signed(e_reg[ID[n]]);
                cof_reg[n] <= diff;
            end
        end
        assign q_data[n*CW +: CW] = cof_reg[n];
    end

    for (genvar j = 0; j < 3; j++) begin : g_row
        always_ff @(posedge aclk) begin
            if (adv) begin
                row2_reg[j] <= e_reg[j];
                row3_reg[j] <= row2_reg[j];
            end
        end
        assign q_data[9*CW + j*E +: E] = row3_reg[j];
    end
endmodule

[hdl/mi3_div_lane.sv]
// One divide lane: rounded, saturated quotient of a cofactor by the determinant.
`timescale 1ns / 1ps
module mi3_div_lane #(
    parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [2*ELEM_BITS-1:0]   cmag,
    input  logic                     cneg,
    input  logic [3*ELEM_BITS+1:0]   dmag,
    output logic [ELEM_BITS-1:0]     res,
    output logic                     sat
);
    localparam int E  = ELEM_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = 3 * E + 2;
    localparam int NW = 2 * E + 2 * F + 1;
    localparam int SW = DW + E + 1;
    localparam int W  = (NW > SW) ? NW : SW;
    localparam int NS = E + 2;

    logic [W-1:0]  rem_reg [NS-1];
    logic [DW-1:0] d_reg   [NS-1];
    logic [E:0]    q_reg   [NS];
    logic          neg_reg [NS];
    logic          ovf_reg [NS];

    logic [W-1:0]  num_w, dsh;
    logic [E+1:0]  qsum;
    logic [E:0]    qr, lim, bound, rmag, sres;
    logic          big;

    // doubled numerator: |C| * 2^(2F+1); quotient must stay below 2^(E+1)
    assign num_w = {{(W-2*E){1'b0}}, cmag} << (2 * F + 1);
    assign dsh   = {{(W-DW){1'b0}}, dmag} << (E + 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_w;
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            neg_reg[0] <= cneg;
            ovf_reg[0] <= (num_w >= dsh);
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_bit
        localparam int K = E + 1 - s;
        logic [W-1:0] dk;
        logic         ge;
        assign dk = {{(W-DW){1'b0}}, d_reg[s-1]} << K;
        assign ge = (rem_reg[s-1] >= dk);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[s]   <= q_reg[s-1] | ((E+1)'(ge) << K);
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end

        if (s < NS - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= ge ? (rem_reg[s-1] - dk) : rem_reg[s-1];
                    d_reg[s]   <= d_reg[s-1];
                end
            end
        end
    end

    // floor(2n/d) -> round half away from zero of n/d
    assign qsum  = {1'b0, q_reg[NS-1]} + (E+2)'(1);
    assign qr    = qsum[E+1:1];
    assign lim   = (E+1)'(1) << (E - 1);
    assign bound = neg_reg[NS-1] ? lim : (lim - (E+1)'(1));
    assign big   = ovf_reg[NS-1] || (qr > bound);
    assign rmag  = big ? bound : qr;
    assign sres  = neg_reg[NS-1] ? ((E+1)'(0) - rmag) : rmag;

    always_ff @(posedge aclk) begin
        if (en) begin
            res <= sres[E-1:0];
            sat <= big;
        end
    end
endmodule

[hdl/mi3_back.sv]
// Back end: determinant, then nine pipelined divide lanes and the output stage.
`timescale 1ns / 1ps
module mi3_back #(
    parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [3*ELEM_BITS+9*(2*ELEM_BITS+1)-1:0] q_data,
    input  mi3_pkg::mi3_qstat_t                     q_stat,
    output logic                                    q_pop,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output logic [9*ELEM_BITS-1:0]                  res_flat,
    output logic                                    singular,
    output logic                                    saturated
);
    import mi3_pkg::*;

    localparam int E   = ELEM_BITS;
    localparam int CW  = 2 * E + 1;
    localparam int DW  = 3 * E + 2;
    localparam int LAT = E + 3;

    logic [CW-1:0]          cof_q [9];
    logic [E-1:0]           row_q [3];
    logic signed [2*E:0]    plo_reg [3];
    logic signed [2*E:0]    phi_reg [3];
    logic [DW-1:0]          term_reg [3];
    logic [DW-1:0]          det_reg;
    logic [2*E-1:0]         cm1_reg [9], cm2_reg [9], cm3_reg [9], cm4_reg [9];
    logic                   cn1_reg [9], cn2_reg [9], cn3_reg [9], neg4_reg [9];
    logic [DW-1:0]          dmag4_reg, det_abs;
    logic                   sing4_reg;
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   vp_reg [LAT];
    logic                   sp_reg [LAT];
    logic [E-1:0]           lane_res [9];
    logic                   lane_sat [9];
    logic [8:0]             sat_vec;
    logic                   adv;

    assign adv     = !(vp_reg[LAT-1] && !m_ready);
    assign q_pop   = adv && !q_stat.empty;
    assign m_valid = vp_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int i = 0; i < LAT; i++) begin
                vp_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= !q_stat.empty;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vp_reg[0] <= v4_reg;
            for (int i = 1; i < LAT; i++) begin
                vp_reg[i] <= vp_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp_reg[0] <= sing4_reg;
            for (int i = 1; i < LAT; i++) begin
                sp_reg[i] <= sp_reg[i-1];
            end
        end
    end

    // row-0 terms: element times cofactor, split into two narrow products
    for (genvar j = 0; j < 3; j++) begin : g_term
        logic [E-1:0] c_lo;
        logic [E:0]   c_hi;
        logic [DW-1:0] hi_ext, lo_ext;
        assign row_q[j] = q_data[9*CW + j*E +: E];
        assign c_lo     = cof_q[j][E-1:0];
        assign c_hi     = cof_q[j][CW-1:E];
        assign hi_ext   = {{(E+1){phi_reg[j][2*E]}}, phi_reg[j]} << E;
        assign lo_ext   = {{(E+1){plo_reg[j][2*E]}}, plo_reg[j]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                plo_reg[j]  <= $signed(row_q[j]) * $signed({1'b0, c_lo});
                phi_reg[j]  <= $signed(row_q[j]) * $signed(c_hi);
                term_reg[j] <= hi_ext + lo_ext;
            end
        end
    end

    for (genvar n = 0; n < 9; n++) begin : g_cm
        logic [CW-1:0] c_abs;
        assign cof_q[n] = q_data[n*CW +: CW];
        assign c_abs    = cof_q[n][CW-1] ? (CW'(0) - cof_q[n]) : cof_q[n];

        always_ff @(posedge aclk) begin
            if (adv) begin
                cm1_reg[n]  <= c_abs[2*E-1:0];
                cn1_reg[n]  <= cof_q[n][CW-1];
                cm2_reg[n]  <= cm1_reg[n];
                cn2_reg[n]  <= cn1_reg[n];
                cm3_reg[n]  <= cm2_reg[n];
                cn3_reg[n]  <= cn2_reg[n];
                cm4_reg[n]  <= cm3_reg[n];
                neg4_reg[n] <= cn3_reg[n] ^ det_reg[DW-1];
            end
        end
    end

    assign det_abs = det_reg[DW-1] ? (DW'(0) - det_reg) : det_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg   <= term_reg[0] + term_reg[1] + term_reg[2];
            dmag4_reg <= det_abs;
            sing4_reg <= (det_reg == '0);
        end
    end

    // result (i,j) divides cofactor (j,i)
    for (genvar k = 0; k < 9; k++) begin : g_lane
        localparam int SRC = (k % 3) * 3 + (k / 3);
        mi3_div_lane #(
            .ELEM_BITS(ELEM_BITS),
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .en   (adv),
            .cmag (cm4_reg[SRC]),
            .cneg (neg4_reg[SRC]),
            .dmag (dmag4_reg),
            .res  (lane_res[k]),
            .sat  (lane_sat[k])
        );
        assign res_flat[k*E +: E] = sp_reg[LAT-1] ? '0 : lane_res[k];
        assign sat_vec[k]         = lane_sat[k];
    end

    assign singular  = sp_reg[LAT-1];
    assign saturated = !sp_reg[LAT-1] && (|sat_vec);
endmodule

[hdl/mat3_inverse_adjugate.sv]
// Top level of the 3x3 fixed-point matrix inverse by adjugate.
//
//  channel | ports                     | role
//  --------+---------------------------+---------------------------------------
//  input   | s_valid s_ready s_m00..22 | one matrix per item, signed Q(E-F).F
//  result  | m_valid m_ready m_r00..22 | inverse, saturated, plus m_singular
//          | m_singular m_saturated    | and m_saturated flags
//
// Throughput: one item per cycle sustained while m_ready stays high; the divide
// lanes are fully pipelined, one quotient bit per stage.
// Path from acceptance to m_valid: the cofactor front, the queue, the determinant
// stages and then the divide lanes.
// Reset: synchronous, active low; clears all valid flags and the queue.
// Stalls: the queue lets the cofactor front keep taking items while the back
// end holds on m_ready; s_ready drops only once the queue is full.
`timescale 1ns / 1ps
module mat3_inverse_adjugate #(
    parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ELEM_BITS-1:0] s_m00,
    input  logic [ELEM_BITS-1:0] s_m01,
    input  logic [ELEM_BITS-1:0] s_m02,
    input  logic [ELEM_BITS-1:0] s_m10,
    input  logic [ELEM_BITS-1:0] s_m11,
    input  logic [ELEM_BITS-1:0] s_m12,
    input  logic [ELEM_BITS-1:0] s_m20,
    input  logic [ELEM_BITS-1:0] s_m21,
    input  logic [ELEM_BITS-1:0] s_m22,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ELEM_BITS-1:0] m_r00,
    output logic [ELEM_BITS-1:0] m_r01,
    output logic [ELEM_BITS-1:0] m_r02,
    output logic [ELEM_BITS-1:0] m_r10,
    output logic [ELEM_BITS-1:0] m_r11,
    output logic [ELEM_BITS-1:0] m_r12,
    output logic [ELEM_BITS-1:0] m_r20,
    output logic [ELEM_BITS-1:0] m_r21,
    output logic [ELEM_BITS-1:0] m_r22,
    output logic                 m_singular,
    output logic                 m_saturated
);
    import mi3_pkg::*;

    localparam int E  = ELEM_BITS;
    // queue entry: nine cofactors, then row 0 of the matrix
    localparam int QW = 3 * E + 9 * (2 * E + 1);

    logic          q_push, q_pop;
    logic [QW-1:0] q_wdata, q_rdata;
    mi3_qstat_t    q_stat;
    logic [9*E-1:0] res_flat;

    mi3_front #(
        .ELEM_BITS(ELEM_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_m00   (s_m00),
        .s_m01   (s_m01),
        .s_m02   (s_m02),
        .s_m10   (s_m10),
        .s_m11   (s_m11),
        .s_m12   (s_m12),
        .s_m20   (s_m20),
        .s_m21   (s_m21),
        .s_m22   (s_m22),
        .q_push  (q_push),
        .q_data  (q_wdata),
        .q_stat  (q_stat)
    );

    mi3_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    mi3_back #(
        .ELEM_BITS(ELEM_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_data    (q_rdata),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .res_flat  (res_flat),
        .singular  (m_singular),
        .saturated (m_saturated)
    );

    assign m_r00 = res_flat[0*E +: E];
    assign m_r01 = res_flat[1*E +: E];
    assign m_r02 = res_flat[2*E +: E];
    assign m_r10 = res_flat[3*E +: E];
    assign m_r11 = res_flat[4*E +: E];
    assign m_r12 = res_flat[5*E +: E];
    assign m_r20 = res_flat[6*E +: E];
    assign m_r21 = res_flat[7*E +: E];
    assign m_r22 = res_flat[8*E +: E];
endmodule

[hdl/mi3_chk.sv]
// Port-level checker for the 3x3 inverse block, bound to the top level.
`timescale 1ns / 1ps
`include "mat3_inverse_adjugate_defines.svh"
module mi3_chk #(
    parameter int ELEM_BITS = mi3_pkg::ELEM_BITS_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [ELEM_BITS-1:0] s_m00,
    input logic [ELEM_BITS-1:0] s_m01,
    input logic [ELEM_BITS-1:0] s_m02,
    input logic [ELEM_BITS-1:0] s_m10,
    input logic [ELEM_BITS-1:0] s_m11,
    input logic [ELEM_BITS-1:0] s_m12,
    input logic [ELEM_BITS-1:0] s_m20,
    input logic [ELEM_BITS-1:0] s_m21,
    input logic [ELEM_BITS-1:0] s_m22,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [ELEM_BITS-1:0] m_r00,
    input logic [ELEM_BITS-1:0] m_r01,
    input logic [ELEM_BITS-1:0] m_r02,
    input logic [ELEM_BITS-1:0] m_r10,
    input logic [ELEM_BITS-1:0] m_r11,
    input logic [ELEM_BITS-1:0] m_r12,
    input logic [ELEM_BITS-1:0] m_r20,
    input logic [ELEM_BITS-1:0] m_r21,
    input logic [ELEM_BITS-1:0] m_r22,
    input logic                 m_singular,
    input logic                 m_saturated
);
    logic [9*ELEM_BITS-1:0] res_bus;
    logic [9*ELEM_BITS+1:0] out_bus;
    logic                   sing_ok;

    assign res_bus = {m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22};
    assign out_bus = {res_bus, m_singular, m_saturated};
    assign sing_ok = (res_bus == '0) && !m_saturated;

    // singular item: zero elements and no clamp flag
    `MI3_ASSERT_NOW(a_singular_zero, m_valid && m_singular, sing_ok, "singular result not zero")

    // nothing comes out in the first cycle after reset
    `MI3_ASSERT_NOW(a_reset_quiet, !$past(aresetn), !m_valid, "result valid right after reset")

    `MI3_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    `MI3_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(out_bus), "stalled result changed")
endmodule

bind mat3_inverse_adjugate mi3_chk #(.ELEM_BITS(ELEM_BITS)) u_mi3_chk (.*);

[tb/tb_top.sv]
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
`timescale 1ns / 1ps
module tb_top;
    import mi3_pkg::*;

    localparam int EB = ELEM_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1130;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = EB + 30;

    // nine elements, index = row*3 + col
    typedef logic [8:0][EB-1:0] mat_t;
    typedef struct packed {
        mat_t elems;
        logic singular;
        logic saturated;
    } inverse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mat_t s_mat = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    mat_t m_mat;
    logic m_singular, m_saturated;

    always #4 aclk = ~aclk;

    mat3_inverse_adjugate u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_mat[0]), .s_m01(s_mat[1]), .s_m02(s_mat[2]),
        .s_m10(s_mat[3]), .s_m11(s_mat[4]), .s_m12(s_mat[5]),
        .s_m20(s_mat[6]), .s_m21(s_mat[7]), .s_m22(s_mat[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r00(m_mat[0]), .m_r01(m_mat[1]), .m_r02(m_mat[2]),
        .m_r10(m_mat[3]), .m_r11(m_mat[4]), .m_r12(m_mat[5]),
        .m_r20(m_mat[6]), .m_r21(m_mat[7]), .m_r22(m_mat[8]),
        .m_singular(m_singular), .m_saturated(m_saturated)
    );

    mat_t     matrix_q[$];    // matrices waiting to be offered
    inverse_t inverse_q[$];   // expected inverses, oldest first
    int       errors = 0;
    int       results_seen = 0;
    int       singular_seen = 0;
    int       saturated_seen = 0;
    int       cycles = 0;
    int       holdoff_left = 0;
    bit       no_gaps = 1'b0;

    // Exact adjugate inverse: cofactors and determinant held at full width,
    // each element one rounded quotient, ties away from zero, then clamped.
    function automatic inverse_t invert_matrix(mat_t m);
        logic signed [127:0] e[9];
        logic signed [127:0] cf[9];
        logic signed [127:0] det;
        logic [127:0] dmag, nmag, quo, rem, bound;
        logic neg;
        inverse_t res;
        for (int k = 0; k < 9; k++) e[k] = $signed(m[k]);
        cf[0] =   e[4] * e[8] - e[5] * e[7];
        cf[1] = -(e[3] * e[8] - e[5] * e[6]);
        cf[2] =   e[3] * e[7] - e[4] * e[6];
        cf[3] = -(e[1] * e[8] - e[2] * e[7]);
        cf[4] =   e[0] * e[8] - e[2] * e[6];
        cf[5] = -(e[0] * e[7] - e[1] * e[6]);
        cf[6] =   e[1] * e[5] - e[2] * e[4];
        cf[7] = -(e[0] * e[5] - e[2] * e[3]);
        cf[8] =   e[0] * e[4] - e[1] * e[3];
        det = e[0] * cf[0] + e[1] * cf[1] + e[2] * cf[2];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        dmag = det < 0 ? -det : det;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // transpose: r[i][j] takes cofactor [j][i]
                nmag = cf[j*3+i] < 0 ? -cf[j*3+i] : cf[j*3+i];
                neg = (cf[j*3+i] < 0) != (det < 0);
                nmag = nmag << (2 * FB);
                quo = nmag / dmag;
                rem = nmag % dmag;
                if ((rem << 1) >= dmag) quo = quo + 1;
                bound = neg ? (128'd1 << (EB - 1)) : (128'd1 << (EB - 1)) - 1;
                if (quo > bound) begin
                    quo = bound;
                    res.saturated = 1'b1;
                end
                if (neg) quo = -quo;
                res.elems[i*3+j] = quo[EB-1:0];
            end
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones; none at all in no-gap stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [EB-1:0] rand_elem(int kind);
        case (kind)
            0: return EB'($urandom);                                   // any bit pattern
            1: return EB'($signed($urandom_range(0, 2 ** (FB + 2))) - 2 ** (FB + 1));
            default: return EB'($signed($urandom_range(0, 64)) - 32);  // tiny values
        endcase
    endfunction

    // Driver: a new item is loaded once the current one is taken or none is up, after any gap drawn has run out.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) inverse_q.push_back(invert_matrix(s_mat));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (matrix_q.size() > 0) begin
                    s_mat <= matrix_q.pop_front();
                    s_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every taken result with the oldest expected inverse, and drive m_ready with gaps and hold-off.
    int recv_gap = 0;
    always @(posedge aclk) begin
        inverse_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_singular) singular_seen++;
                if (m_saturated) saturated_seen++;
                if (inverse_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item at cycle %0d", cycles);
                end else begin
                    want = inverse_q.pop_front();
                    if (want != {m_mat, m_singular, m_saturated}) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch item %0d: exp %h sing %b sat %b, got %h sing %b sat %b",
                                     results_seen, want.elems, want.singular, want.saturated,
                                     m_mat, m_singular, m_saturated);
                    end
                end
            end
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge aclk) if (holdoff_left > 0) holdoff_left <= holdoff_left - 1;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** mat3_inverse_adjugate: FAILED **");
            $finish;
        end
    end

    initial begin
        mat_t m;
        int kind;
        localparam logic [EB-1:0] ONE  = EB'(1 << FB);
        localparam logic [EB-1:0] MAXV = {1'b0, {(EB-1){1'b1}}};
        localparam logic [EB-1:0] MINV = {1'b1, {(EB-1){1'b0}}};

        // directed: identity, zero, extremes, singular, saturating, negatives
        matrix_q.push_back({ONE, EB'(0), EB'(0), EB'(0), ONE, EB'(0), EB'(0), EB'(0), ONE});
        matrix_q.push_back('0);
        matrix_q.push_back({9{MAXV}});
        matrix_q.push_back({9{MINV}});
        matrix_q.push_back({MAXV, EB'(0), EB'(0), EB'(0), MAXV, EB'(0), EB'(0), EB'(0), MAXV});
        matrix_q.push_back({MINV, EB'(0), EB'(0), EB'(0), MINV, EB'(0), EB'(0), EB'(0), MINV});
        matrix_q.push_back({EB'(1), EB'(0), EB'(0), EB'(0), EB'(1), EB'(0), EB'(0), EB'(0), EB'(1)});
        matrix_q.push_back({-EB'(1), EB'(0), EB'(0), EB'(0), EB'(1), EB'(0), EB'(0), EB'(0), EB'(1)});
        matrix_q.push_back({MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, EB'(0)});
        matrix_q.push_back({MINV, MAXV, EB'(1), EB'(0), MINV, MAXV, MAXV, EB'(0), MINV});
        matrix_q.push_back({-ONE, EB'(0), EB'(0), EB'(0), -(ONE << 1), EB'(0), EB'(0), EB'(0), ONE << 2});
        matrix_q.push_back({ONE, ONE << 1, ONE, ONE << 1, ONE << 2, ONE << 1, ONE, ONE, ONE});
        matrix_q.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        matrix_q.push_back({EB'(ONE * 3), EB'(0), EB'(0), EB'(0), EB'(ONE * 3), EB'(0), EB'(0),
                            EB'(0), EB'(ONE * 3)});
        matrix_q.push_back({EB'(0), ONE, EB'(0), ONE, EB'(0), EB'(0), EB'(0), EB'(0), ONE});
        matrix_q.push_back({EB'(2), EB'(0), EB'(0), EB'(0), EB'(3), EB'(0), EB'(0), EB'(0), EB'(5)});

        // random: full patterns, well-conditioned, third row built from entries of the first two, tiny (saturating)
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(9);
            if (kind < 3) begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(0);
            end else if (kind < 7) begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(1);
                for (int k = 0; k < 3; k++) m[k*4] = m[k*4] + EB'(4 << FB);
            end else if (kind < 8) begin
                for (int k = 0; k < 6; k++) m[k] = rand_elem($urandom_range(2));
                for (int k = 0; k < 3; k++) m[6+k] = m[$urandom_range(1) * 3 + k];
            end else begin
                for (int k = 0; k < 9; k++) m[k] = rand_elem(2);
            end
            matrix_q.push_back(m);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // once the directed items are in, hold the result side off long enough
        // for the pipeline and queue to fill and back up onto s_ready
        wait (matrix_q.size() < N_RANDOM - 20);
        @(posedge aclk);
        holdoff_left <= 300;
        wait (matrix_q.size() < N_RANDOM / 2);
        no_gaps = 1'b1;
        wait (matrix_q.size() < N_RANDOM / 3);
        no_gaps = 1'b0;

        wait (matrix_q.size() == 0 && !s_valid && inverse_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (inverse_q.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", inverse_q.size());
        end
        $display("covered %0d matrices: %0d singular, %0d with clamped elements, %0d errors",
                 results_seen, singular_seen, saturated_seen, errors);
        if (errors == 0) begin
            $display("** mat3_inverse_adjugate: PASSED **");
        end else begin
            $display("** mat3_inverse_adjugate: FAILED **");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/mi3_pkg.sv
hdl/mi3_queue.sv
hdl/mi3_front.sv
hdl/mi3_div_lane.sv
hdl/mi3_back.sv
hdl/mat3_inverse_adjugate.sv
hdl/mi3_chk.sv
tb/tb_top.sv
